>>> design/vslpf_pkg.sv
// Shared constants, types and command/status structs for the variable-step low-pass filter.
package vslpf_pkg;

   // Fraction bits of the smoothing factor alpha
   localparam int ALPHA_FRAC_BITS = 16;

   // Field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int TAU_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // Q16.16 filter state
   localparam int STATE_W = 32;
   localparam int FRAC_W  = 16;

   // Divider: quotient covers 0 .. 1.0 inclusive
   localparam int ALPHA_W   = ALPHA_FRAC_BITS + 1;
   localparam int DEN_W     = TAU_W + 1;
   localparam int DIV_STEPS = ALPHA_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Update arithmetic
   localparam int DIFF_W = STATE_W + 1;
   localparam int PROD_W = DIFF_W + ALPHA_W + 1;
   localparam int STEP_W = PROD_W - ALPHA_FRAC_BITS;
   localparam int Y_W    = STEP_W + 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
   localparam logic [TAU_W-1:0]   TAU_RESET = TAU_W'(1000);
   localparam logic [STATE_W-1:0] STATE_MAX = 32'h7FFF_0000;
   localparam logic [STATE_W-1:0] STATE_MIN = 32'h8000_0000;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAU           = 1'b0,
      CSR_INITIAL_LEVEL = 1'b1
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic setup;
      logic div_step;
      logic multiply;
      logic update;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic restart;
      logic div_done;
   } status_type;

endpackage

>>> design/variable_step_lowpass_filter.sv
// Top level of the variable-step first-order low-pass filter.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_ready     req_sample, req_timestamp, req_restart
//   rsp_      out        rsp_valid / rsp_ready     rsp_filtered
//   csr_      in         csr_write_enable          csr_index, csr_write_data
//
// A filtering item passes from accept to result valid through setup, the restoring divider
// that forms alpha (one quotient bit a cycle), a multiply, an update and the load of the
// output register. A restart item goes from setup straight to the output load. Items are
// accepted in the idle state; one item is processed at a time.
// Reset is synchronous and restores tau to 1000, the initial level, time and state to zero.
// A stalled result is held in the output register while the next item is accepted and
// processed; that item waits in its final step, with the input closed, until the register
// is free.
module variable_step_lowpass_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [vslpf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [vslpf_pkg::TIME_W-1:0]          req_timestamp,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [vslpf_pkg::SAMPLE_W-1:0] rsp_filtered,
   input  logic                                  csr_write_enable,
   input  logic [vslpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vslpf_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   vslpf_pkg::cmd_type    cmd;
   vslpf_pkg::status_type status;

   vslpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   vslpf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample       (req_sample),
      .req_timestamp    (req_timestamp),
      .req_restart      (req_restart),
      .rsp_filtered     (rsp_filtered),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> design/vslpf_ctrl.sv
// Controller state machine: sequences load, divide, multiply, update and result hand-off.
module vslpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vslpf_pkg::cmd_type     cmd,
   input  vslpf_pkg::status_type  status
);

   vslpf_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vslpf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;

      // Drop the held item once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         vslpf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = vslpf_pkg::ST_SETUP;
            end
         end
         vslpf_pkg::ST_SETUP: begin
            if (status.restart) begin
               state_in = vslpf_pkg::ST_FINISH;
            end else begin
               cmd.setup = 1'b1;
               state_in  = vslpf_pkg::ST_DIVIDE;
            end
         end
         vslpf_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = vslpf_pkg::ST_MULTIPLY;
            end
         end
         vslpf_pkg::ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = vslpf_pkg::ST_UPDATE;
         end
         vslpf_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = vslpf_pkg::ST_FINISH;
         end
         vslpf_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = vslpf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vslpf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // One item in flight: an accept closes the input until the result is loaded into the output register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while an item is in flight");

   // A new result never overwrites one that has not been taken
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // The divider always runs after setup
   assert property (@(posedge clock) disable iff (reset)
      cmd.setup |=> (state_ff == vslpf_pkg::ST_DIVIDE))
      else $error("setup not followed by divide");

endmodule

>>> design/vslpf_datapath.sv
// Datapath: configuration registers, serial divider for alpha, multiply and state update.
module vslpf_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [vslpf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [vslpf_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  logic signed [vslpf_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic [vslpf_pkg::TIME_W-1:0]             req_timestamp,
   input  logic                                     req_restart,
   output logic signed [vslpf_pkg::SAMPLE_W-1:0]    rsp_filtered,
   input  vslpf_pkg::cmd_type                       cmd,
   output vslpf_pkg::status_type                    status
);

   // Configuration
   logic [vslpf_pkg::TAU_W-1:0]    tau_ff, tau_in;
   logic [vslpf_pkg::SAMPLE_W-1:0] init_level_ff, init_level_in;

   // Filter state
   logic [vslpf_pkg::TIME_W-1:0]  last_time_ff, last_time_in;
   logic [vslpf_pkg::STATE_W-1:0] smoothed_ff, smoothed_in;

   // Per-item working registers
   logic [vslpf_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic                           restart_ff, restart_in;
   logic [vslpf_pkg::TIME_W-1:0]   dt_ff, dt_in;
   logic [vslpf_pkg::DEN_W-1:0]    den_ff, den_in;
   logic                           den_zero_ff, den_zero_in;
   logic [vslpf_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic                           num_bit_ff, num_bit_in;
   logic [vslpf_pkg::ALPHA_W-1:0]  q_ff, q_in;
   logic [vslpf_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [vslpf_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic signed [vslpf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [vslpf_pkg::SAMPLE_W-1:0] out_ff, out_in;

   // Combinational helpers
   logic [vslpf_pkg::DEN_W-1:0]         den_sum;
   logic [vslpf_pkg::DEN_W:0]           rem_shift;
   logic [vslpf_pkg::DEN_W:0]           rem_sub;
   logic [vslpf_pkg::ALPHA_W-1:0]       alpha_sel;
   logic signed [vslpf_pkg::PROD_W-1:0] prod_rnd;
   logic signed [vslpf_pkg::STEP_W-1:0] step;
   logic signed [vslpf_pkg::Y_W-1:0]    y_sum;
   logic signed [vslpf_pkg::Y_W-1:0]    y_max;
   logic signed [vslpf_pkg::Y_W-1:0]    y_min;
   logic [vslpf_pkg::STATE_W-1:0]       y_clamped;
   logic [vslpf_pkg::STATE_W:0]         r_sum;
   logic [vslpf_pkg::SAMPLE_W:0]        r_int;

   // Configuration writes
   always_comb begin
      tau_in        = tau_ff;
      init_level_in = init_level_ff;
      if (csr_write_enable) begin
         case (vslpf_pkg::csr_index_type'(csr_index))
            vslpf_pkg::CSR_TAU:           tau_in = csr_write_data[vslpf_pkg::TAU_W-1:0];
            vslpf_pkg::CSR_INITIAL_LEVEL: init_level_in =
                                             csr_write_data[vslpf_pkg::SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Divider: restoring, one quotient bit a cycle
   assign den_sum   = {1'b0, tau_ff} + {1'b0, dt_ff};
   assign rem_shift = {rem_ff, num_bit_ff};
   assign rem_sub   = rem_shift - {1'b0, den_ff};

   // Alpha is exactly one when the denominator vanishes
   assign alpha_sel = den_zero_ff ? vslpf_pkg::ALPHA_ONE : q_ff;

   // Round the step to nearest, ties up, then floor-shift
   assign prod_rnd = prod_ff + $signed({{(vslpf_pkg::PROD_W - vslpf_pkg::ALPHA_FRAC_BITS){1'b0}},
                                        1'b1, {(vslpf_pkg::ALPHA_FRAC_BITS-1){1'b0}}});
   assign step     = prod_rnd[vslpf_pkg::PROD_W-1:vslpf_pkg::ALPHA_FRAC_BITS];
   assign y_sum    = $signed({{(vslpf_pkg::Y_W - vslpf_pkg::STATE_W){smoothed_ff[vslpf_pkg::STATE_W-1]}},
                               smoothed_ff})
                   + $signed({step[vslpf_pkg::STEP_W-1], step});
   assign y_max    = $signed({{(vslpf_pkg::Y_W - vslpf_pkg::STATE_W){1'b0}}, vslpf_pkg::STATE_MAX});
   assign y_min    = $signed({{(vslpf_pkg::Y_W - vslpf_pkg::STATE_W){1'b1}}, vslpf_pkg::STATE_MIN});

   always_comb begin
      if (y_sum > y_max) begin
         y_clamped = vslpf_pkg::STATE_MAX;
      end else if (y_sum < y_min) begin
         y_clamped = vslpf_pkg::STATE_MIN;
      end else begin
         y_clamped = y_sum[vslpf_pkg::STATE_W-1:0];
      end
   end

   // Round the state to an integer sample, ties up, and clamp
   assign r_sum = {smoothed_ff[vslpf_pkg::STATE_W-1], smoothed_ff}
                + {{(vslpf_pkg::STATE_W + 1 - vslpf_pkg::FRAC_W){1'b0}},
                   1'b1, {(vslpf_pkg::FRAC_W-1){1'b0}}};
   assign r_int = r_sum[vslpf_pkg::STATE_W:vslpf_pkg::FRAC_W];

   // Next values of the working registers
   always_comb begin
      last_time_in = last_time_ff;
      smoothed_in  = smoothed_ff;
      x_in         = x_ff;
      restart_in   = restart_ff;
      dt_in        = dt_ff;
      den_in       = den_ff;
      den_zero_in  = den_zero_ff;
      rem_in       = rem_ff;
      num_bit_in   = num_bit_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      out_in       = out_ff;

      // Capture the item and the elapsed time
      if (cmd.load) begin
         x_in         = req_sample;
         restart_in   = req_restart;
         dt_in        = req_timestamp - last_time_ff;
         last_time_in = req_timestamp;
         if (req_restart) begin
            smoothed_in = {init_level_ff, {vslpf_pkg::FRAC_W{1'b0}}};
         end
      end

      // Prime the divider and form x - y
      if (cmd.setup) begin
         den_in      = den_sum;
         den_zero_in = (den_sum == '0);
         rem_in      = {2'b00, dt_ff[vslpf_pkg::TIME_W-1:1]};
         num_bit_in  = dt_ff[0];
         q_in        = '0;
         cnt_in      = vslpf_pkg::CNT_W'(vslpf_pkg::DIV_STEPS - 1);
         diff_in     = $signed({x_ff[vslpf_pkg::SAMPLE_W-1], x_ff, {vslpf_pkg::FRAC_W{1'b0}}})
                     - $signed({smoothed_ff[vslpf_pkg::STATE_W-1], smoothed_ff});
      end

      // Advance one quotient bit
      if (cmd.div_step) begin
         num_bit_in = 1'b0;
         cnt_in     = cnt_ff - 1'b1;
         if (!rem_sub[vslpf_pkg::DEN_W]) begin
            rem_in = rem_sub[vslpf_pkg::DEN_W-1:0];
            q_in   = {q_ff[vslpf_pkg::ALPHA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[vslpf_pkg::DEN_W-1:0];
            q_in   = {q_ff[vslpf_pkg::ALPHA_W-2:0], 1'b0};
         end
      end

      if (cmd.multiply) begin
         prod_in = diff_ff * $signed({1'b0, alpha_sel});
      end

      if (cmd.update) begin
         smoothed_in = y_clamped;
      end

      // Load the output register
      if (cmd.emit) begin
         if (!r_int[vslpf_pkg::SAMPLE_W] && r_int[vslpf_pkg::SAMPLE_W-1]) begin
            out_in = {1'b0, {(vslpf_pkg::SAMPLE_W-1){1'b1}}};
         end else if (r_int[vslpf_pkg::SAMPLE_W] && !r_int[vslpf_pkg::SAMPLE_W-1]) begin
            out_in = {1'b1, {(vslpf_pkg::SAMPLE_W-1){1'b0}}};
         end else begin
            out_in = r_int[vslpf_pkg::SAMPLE_W-1:0];
         end
      end
   end

   // Architectural state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff        <= vslpf_pkg::TAU_RESET;
         init_level_ff <= '0;
         last_time_ff  <= '0;
         smoothed_ff   <= '0;
      end else begin
         tau_ff        <= tau_in;
         init_level_ff <= init_level_in;
         last_time_ff  <= last_time_in;
         smoothed_ff   <= smoothed_in;
      end
   end

   // Working registers, no reset
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      restart_ff  <= restart_in;
      dt_ff       <= dt_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
      rem_ff      <= rem_in;
      num_bit_ff  <= num_bit_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      out_ff      <= out_in;
   end

   assign status.restart  = restart_ff;
   assign status.div_done = (cnt_ff == '0);
   assign rsp_filtered    = out_ff;

   // Quotient never exceeds one when the denominator is nonzero
   assert property (@(posedge clock) disable iff (reset)
      (cmd.multiply && !den_zero_ff) |-> (q_ff <= vslpf_pkg::ALPHA_ONE))
      else $error("divider quotient above one");

   // Partial remainder stays below the divisor while dividing
   assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !den_zero_ff) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

endmodule
